// ===== rtl/fast_inverse_square_root_assert.svh =====
// ----------------------------------------------------------------------------
// Fast inverse square root: assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef FAST_INVERSE_SQUARE_ROOT_ASSERT_SVH
`define FAST_INVERSE_SQUARE_ROOT_ASSERT_SVH

// checked out of reset only
`define FISR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked in and out of reset
`define FISR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/fisr_pkg.sv =====
// ----------------------------------------------------------------------------
// Fast inverse square root: package
// Binary32 multiply and add with round to nearest even, pipeline types.
// ----------------------------------------------------------------------------
package fisr_pkg;

    localparam logic [31:0] SEED_MAGIC = 32'h5f3759df;
    localparam logic [31:0] FP_HALF    = 32'h3f000000;
    localparam logic [31:0] FP_THREE_HALVES = 32'h3fc00000;
    localparam logic [31:0] CANON_NAN  = 32'h7fc00000;
    localparam int unsigned NUM_STAGES = 5;

    typedef struct packed {
        logic valid;
        logic run;
        logic act;
    } t_ctl;

    function automatic logic is_nan(input logic [31:0] a);
        return (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic         s;
        logic [23:0]  ma;
        logic [23:0]  mb;
        logic [47:0]  p;
        logic [121:0] w;
        logic [24:0]  m;
        logic         g;
        logic         st;
        int           ea;
        int           eb;
        int           k;
        int           sh;
        int           e;
        s  = a[31] ^ b[31];
        if (is_nan(a) || is_nan(b)) return CANON_NAN;
        if (a[30:23] == 8'hff) begin
            if (b[30:0] == 31'd0) return CANON_NAN;
            return {s, 8'hff, 23'd0};
        end
        if (b[30:23] == 8'hff) begin
            if (a[30:0] == 31'd0) return CANON_NAN;
            return {s, 8'hff, 23'd0};
        end
        ma = {|a[30:23], a[22:0]};
        mb = {|b[30:23], b[22:0]};
        ea = (a[30:23] == 8'd0) ? 1 : int'(a[30:23]);
        eb = (b[30:23] == 8'd0) ? 1 : int'(b[30:23]);
        p  = ma * mb;
        if (p == 48'd0) return {s, 31'd0};
        k = 0;
        for (int i = 0; i < 48; i++) begin
            if (p[i]) k = i;
        end
        sh = k - 23;
        if (151 - ea - eb > sh) sh = 151 - ea - eb;
        e  = ea + eb - 150 + sh;
        if (sh < 0) begin
            m  = p[24:0] << (-sh);
            g  = 1'b0;
            st = 1'b0;
        end else if (sh > 73) begin
            m  = 25'd0;
            g  = 1'b0;
            st = 1'b1;
        end else begin
            w  = {p, 74'd0} >> sh;
            m  = w[98:74];
            g  = w[73];
            st = |w[72:0];
        end
        if (g && (st || m[0])) m = m + 25'd1;
        if (m[24]) begin
            m = m >> 1;
            e = e + 1;
        end
        if (e >= 255) return {s, 8'hff, 23'd0};
        return {s, (m[23] ? e[7:0] : 8'd0), m[22:0]};
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a_in, input logic [31:0] b_in);
        logic [31:0] a;
        logic [31:0] b;
        logic [26:0] ax;
        logic [26:0] bx;
        logic [26:0] lost;
        logic [27:0] sum;
        logic [24:0] m;
        logic        g;
        logic        st;
        int          ea;
        int          eb;
        int          d;
        int          k;
        int          sh;
        int          e;
        if (is_nan(a_in) || is_nan(b_in)) return CANON_NAN;
        if (a_in[30:23] == 8'hff && b_in[30:23] == 8'hff) begin
            if (a_in[31] != b_in[31]) return CANON_NAN;
            return a_in;
        end
        if (a_in[30:23] == 8'hff) return a_in;
        if (b_in[30:23] == 8'hff) return b_in;
        if (a_in[30:0] < b_in[30:0]) begin
            a = b_in;
            b = a_in;
        end else begin
            a = a_in;
            b = b_in;
        end
        ea = (a[30:23] == 8'd0) ? 1 : int'(a[30:23]);
        eb = (b[30:23] == 8'd0) ? 1 : int'(b[30:23]);
        d  = ea - eb;
        ax = {|a[30:23], a[22:0], 3'd0};
        bx = {|b[30:23], b[22:0], 3'd0};
        if (d > 26) begin
            bx = (bx != 27'd0) ? 27'd1 : 27'd0;
        end else begin
            lost = bx << (27 - d);
            bx   = (bx >> d) | {26'd0, |lost};
        end
        if (a[31] == b[31]) sum = {1'b0, ax} + {1'b0, bx};
        else                sum = {1'b0, ax} - {1'b0, bx};
        if (sum == 28'd0) return {a[31] & b[31], 31'd0};
        e = ea;
        if (sum[27]) begin
            sum = {1'b0, sum[27:1]} | {27'd0, sum[0]};
            e   = e + 1;
        end
        k = 0;
        for (int i = 0; i < 27; i++) begin
            if (sum[i]) k = i;
        end
        sh = 26 - k;
        if (sh > e - 1) sh = e - 1;
        sum = sum << sh;
        e   = e - sh;
        m   = {1'b0, sum[26:3]};
        g   = sum[2];
        st  = |sum[1:0];
        if (g && (st || m[0])) m = m + 25'd1;
        if (m[24]) begin
            m = m >> 1;
            e = e + 1;
        end
        if (e >= 255) return {a[31], 8'hff, 23'd0};
        return {a[31], (m[23] ? e[7:0] : 8'd0), m[22:0]};
    endfunction

endpackage

// ===== rtl/fisr_if.sv =====
// ----------------------------------------------------------------------------
// Fast inverse square root: channel interfaces
// Operand and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface fisr_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] value_bits;
    logic        action;
    modport source (output valid, output value_bits, output action, input ready);
    modport sink   (input valid, input value_bits, input action, output ready);
endinterface

interface fisr_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_bits;
    modport source (output valid, output result_bits, input ready);
    modport sink   (input valid, input result_bits, output ready);
endinterface

// ===== rtl/fisr_pass.sv =====
// ----------------------------------------------------------------------------
// Fast inverse square root: one pass
// Five-stage seed and Newton step; passes the operand through when not run.
// ----------------------------------------------------------------------------
module fisr_pass (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  fisr_pkg::t_ctl i_ctl,
    input  logic [31:0]    i_x,
    output fisr_pkg::t_ctl o_ctl,
    output logic [31:0]    o_y
);
    import fisr_pkg::*;

    t_ctl        r_ctl [NUM_STAGES];
    logic [31:0] r_x [NUM_STAGES-1];
    logic [31:0] r_y [NUM_STAGES-1];
    logic [31:0] r_t [NUM_STAGES-1];
    logic [31:0] r_out;
    logic [31:0] n_prod;

    always_comb begin
        n_prod = fp_mul(r_y[3], r_t[3]);
        if (is_nan(n_prod)) n_prod = CANON_NAN;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_STAGES; i++) r_ctl[i] <= '0;
        end else if (i_en) begin
            r_ctl[0] <= i_ctl;
            for (int i = 1; i < NUM_STAGES; i++) r_ctl[i] <= r_ctl[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= i_x;
            r_y[0] <= SEED_MAGIC - {1'b0, i_x[31:1]};
            r_t[0] <= fp_mul(i_x, FP_HALF);
            for (int i = 1; i < NUM_STAGES-1; i++) begin
                r_x[i] <= r_x[i-1];
                r_y[i] <= r_y[i-1];
            end
            r_t[1] <= fp_mul(r_t[0], r_y[0]);
            r_t[2] <= fp_mul(r_t[1], r_y[1]);
            r_t[3] <= fp_add(FP_THREE_HALVES, r_t[2] ^ 32'h8000_0000);
            r_out  <= r_ctl[3].run ? n_prod : r_x[3];
        end
    end

    assign o_ctl = r_ctl[NUM_STAGES-1];
    assign o_y   = r_out;
endmodule

// ===== rtl/fast_inverse_square_root.sv =====
// ----------------------------------------------------------------------------
// Fast inverse square root
// Binary32 seed plus one Newton step; action 1 runs two passes (fourth root).
// ----------------------------------------------------------------------------
// channel  dir  fields                  handshake
// i_in     in   value_bits, action      valid/ready
// o_out    out  result_bits             valid/ready
//
// Ten register stages, five per pass; one word per cycle while o_out is not stalled.
// Each stage holds one float multiply or add.
// Reset clears the control bits (valid, run, act) only.
// A stall at o_out freezes the whole pipeline; i_in.ready drops with it.
// ----------------------------------------------------------------------------
module fast_inverse_square_root (
    input  logic         i_clk,
    input  logic         i_rst_n,
    fisr_in_if.sink      i_in,
    fisr_out_if.source   o_out
);
    import fisr_pkg::*;

    logic        en;
    t_ctl        in_ctl;
    t_ctl        mid_ctl;
    t_ctl        mid_ctl_run;
    t_ctl        out_ctl;
    logic [31:0] mid_y;
    logic [31:0] out_y;

    assign en = !out_ctl.valid || o_out.ready;
    assign i_in.ready = en;

    assign in_ctl = '{valid: i_in.valid, run: 1'b1, act: i_in.action};
    assign mid_ctl_run = '{valid: mid_ctl.valid, run: mid_ctl.act, act: mid_ctl.act};

    fisr_pass u_pass0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (in_ctl),
        .i_x     (i_in.value_bits),
        .o_ctl   (mid_ctl),
        .o_y     (mid_y)
    );

    fisr_pass u_pass1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (mid_ctl_run),
        .i_x     (mid_y),
        .o_ctl   (out_ctl),
        .o_y     (out_y)
    );

    assign o_out.valid       = out_ctl.valid;
    assign o_out.result_bits = out_y;
endmodule

// ===== rtl/fisr_checker.sv =====
// ----------------------------------------------------------------------------
// Fast inverse square root: port checker
// Handshake and stall behavior seen at the top-level ports.
// ----------------------------------------------------------------------------
`include "fast_inverse_square_root_assert.svh"

module fisr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_result_bits
);
    `FISR_ASSERT_ALWAYS(a_rst_clears, !i_rst_n |=> !i_out_valid, "valid after reset")
    `FISR_ASSERT(a_stall_blocks, (i_out_valid && !i_out_ready) |-> !i_in_ready, "input in stall")
    `FISR_ASSERT(a_valid_holds, (i_out_valid && !i_out_ready) |=> i_out_valid, "word dropped")
    `FISR_ASSERT(a_data_holds, (i_out_valid && !i_out_ready) |=> $stable(i_result_bits), "word changed")
endmodule

bind fast_inverse_square_root fisr_checker u_fisr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_result_bits (o_out.result_bits)
);
